>>> design/spg_pkg.sv
package spg_pkg;

    localparam int WORD_W            = 32;
    localparam int DIRS_PER_DIM      = 32;
    localparam int POS_W             = 5;
    localparam int DEFAULT_DIM_COUNT = 64;

    // Input tdata layout, lowest bit first.
    localparam int DIM_LSB    = 0;
    localparam int DIM_W      = 6;
    localparam int POSN_LSB   = 6;
    localparam int POSN_W     = 6;
    localparam int MVAL_LSB   = 12;
    localparam int DEG_LSB    = 44;
    localparam int DEG_W      = 6;
    localparam int POLY_LSB   = 50;
    localparam int POLY_W     = 31;
    localparam int INDEX_LSB  = 81;
    localparam int IN_TDATA_W = 120;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_EVAL  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_ZERO   = 2'd0,
        MODE_UNIT   = 2'd1,
        MODE_DIRECT = 2'd2,
        MODE_RECUR  = 2'd3
    } t_build_mode;

    typedef struct packed {
        logic                init;
        logic                step;
        t_build_mode         mode;
        logic [DEG_W-1:0]    degree;
        logic [POLY_W-1:0]   poly;
        logic [POS_W-1:0]    pos;
    } t_build_ctrl;

endpackage

>>> design/spg_dir_table.sv
module spg_dir_table #(
    parameter int DEPTH = spg_pkg::DEFAULT_DIM_COUNT * spg_pkg::DIRS_PER_DIM,
    parameter int AW    = $clog2(spg_pkg::DEFAULT_DIM_COUNT) + spg_pkg::POS_W
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [spg_pkg::WORD_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [spg_pkg::WORD_W-1:0]  o_rdata
);
    import spg_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/spg_build_unit.sv
module spg_build_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spg_pkg::t_build_ctrl        i_ctrl,
    input  logic [spg_pkg::WORD_W-1:0]  i_m,
    output logic [spg_pkg::WORD_W-1:0]  o_dir
);
    import spg_pkg::*;

    t_build_mode        r_mode;
    logic [POS_W-1:0]   r_degree;
    logic [30:0]        r_mask;
    logic [WORD_W-1:0]  r_hist [DIRS_PER_DIM];

    logic [30:0]        n_mask;
    logic [31:0]        w_poly;
    logic [WORD_W-1:0]  w_shl_src;
    logic [WORD_W-1:0]  w_shl;
    logic [WORD_W-1:0]  w_tap;
    logic [WORD_W-1:0]  w_fb;

    // Coefficient a_k gates history word V(i-k), which sits at r_hist[k-1].
    assign w_poly = {1'b0, i_ctrl.poly};

    always_comb begin
        logic [DEG_W-1:0] idx;
        n_mask = '0;
        for (int k = 1; k < 32; k++) begin
            idx = i_ctrl.degree - DEG_W'(k) - DEG_W'(1);
            n_mask[k-1] = (DEG_W'(k) < i_ctrl.degree) && w_poly[idx[POS_W-1:0]];
        end
    end

    assign w_shl_src = (r_mode == MODE_UNIT) ? WORD_W'(1) : i_m;
    assign w_shl     = w_shl_src << (POS_W'(31) - i_ctrl.pos);
    assign w_tap     = r_hist[r_degree - POS_W'(1)];

    always_comb begin
        w_fb = w_tap ^ (w_tap >> r_degree);
        for (int k = 0; k < 31; k++) begin
            if (r_mask[k]) begin
                w_fb = w_fb ^ r_hist[k];
            end
        end
    end

    always_comb begin
        case (r_mode)
            MODE_ZERO:   o_dir = '0;
            MODE_RECUR:  o_dir = (i_ctrl.pos < r_degree) ? w_shl : w_fb;
            default:     o_dir = w_shl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ZERO;
        end else if (i_ctrl.init) begin
            r_mode <= i_ctrl.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_degree <= i_ctrl.degree[POS_W-1:0];
            r_mask   <= n_mask;
        end
        if (i_ctrl.step) begin
            r_hist[0] <= o_dir;
            for (int k = 1; k < DIRS_PER_DIM; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

>>> design/sobol_point_generator.sv
// Sobol point generator, 32-bit coordinates.
// Input items arrive on the s_axis channel; tuser carries the operation and
// tdata the operands. A load operation writes one initial direction integer
// into the scratch store and completes in the cycle it is accepted. A build
// operation turns the scratch store into the 32 direction numbers of one
// dimension at one table word per cycle, a rate set by the single
// history/feedback unit and the one write port of the direction table. An
// evaluate operation walks the 32 bits of the sample index, one table read
// per cycle, and XORs the selected words; the point then passes through the
// final state into the output register and is shown on m_axis.
// Only evaluate operations produce an output transfer.
// The input side is ready only while the sequencer is idle. The point waits
// in an output register, and a new item can be taken while it waits there.
// While the receiver stalls, a newly finished point holds in the accumulator
// and the sequencer holds in its final state until the register is free.
// Reset clears the sequencer and the output valid; the scratch store and the
// direction table are not cleared and must be written before they are read.
module sobol_point_generator #(
    parameter int DIM_COUNT = spg_pkg::DEFAULT_DIM_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // dim, position, m_value, degree, poly_bits, sample_index, zero fill
    input  logic [spg_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // point
    output logic [spg_pkg::WORD_W-1:0]      o_m_axis_tdata
);
    import spg_pkg::*;

    localparam int DIM_AW = (DIM_COUNT > 1) ? $clog2(DIM_COUNT) : 1;
    localparam int AW     = DIM_AW + POS_W;
    localparam int DEPTH  = DIM_COUNT * DIRS_PER_DIM;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BUILD = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_cnt;
    logic [DIM_AW-1:0]  r_dim;
    logic               r_dim_ok;
    logic [WORD_W-1:0]  r_index;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_m_rdata;
    logic [WORD_W-1:0]  r_scratch [DIRS_PER_DIM];
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;

    logic               w_accept;
    t_op                w_op;
    logic [DIM_W-1:0]   w_dim;
    logic [POSN_W-1:0]  w_posn;
    logic [WORD_W-1:0]  w_mval;
    logic [DEG_W-1:0]   w_degree;
    logic [POLY_W-1:0]  w_poly;
    logic [WORD_W-1:0]  w_index;
    logic               w_dim_ok;
    logic               w_load_ok;
    logic               w_out_free;
    t_build_mode        w_mode;
    t_build_ctrl        w_ctrl;
    logic [WORD_W-1:0]  w_dir;
    logic [POS_W-1:0]   w_scr_raddr;
    logic [AW-1:0]      w_tbl_raddr;
    logic [WORD_W-1:0]  w_tbl_rdata;

    assign w_op     = t_op'(i_s_axis_tuser);
    assign w_dim    = i_s_axis_tdata[DIM_LSB +: DIM_W];
    assign w_posn   = i_s_axis_tdata[POSN_LSB +: POSN_W];
    assign w_mval   = i_s_axis_tdata[MVAL_LSB +: WORD_W];
    assign w_degree = i_s_axis_tdata[DEG_LSB +: DEG_W];
    assign w_poly   = i_s_axis_tdata[POLY_LSB +: POLY_W];
    assign w_index  = i_s_axis_tdata[INDEX_LSB +: WORD_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_dim_ok        = 32'(w_dim) < 32'(DIM_COUNT);
    assign w_load_ok       = (w_posn != '0) && (w_posn <= POSN_W'(DIRS_PER_DIM));
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // Dimension zero ignores the polynomial; degree zero yields all zeros.
    always_comb begin
        if (w_dim == '0) begin
            w_mode = MODE_UNIT;
        end else if (w_degree == '0) begin
            w_mode = MODE_ZERO;
        end else if (w_degree >= DEG_W'(DIRS_PER_DIM)) begin
            w_mode = MODE_DIRECT;
        end else begin
            w_mode = MODE_RECUR;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_BUILD: n_state = w_dim_ok ? S_BUILD : S_IDLE;
                        OP_EVAL:  n_state = S_EVAL;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_BUILD: begin
                if (r_cnt == POS_W'(DIRS_PER_DIM - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                if (r_cnt == POS_W'(DIRS_PER_DIM - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + POS_W'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operand capture and the evaluate accumulator.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dim    <= DIM_AW'(w_dim);
            r_dim_ok <= w_dim_ok;
            r_index  <= w_index;
            r_acc    <= '0;
        end else if (r_state == S_EVAL && r_dim_ok && r_index[r_cnt]) begin
            r_acc <= r_acc ^ w_tbl_rdata;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= r_acc;
        end
    end

    // Scratch store of m values; the read runs one word ahead of the build step.
    assign w_scr_raddr = (r_state == S_BUILD) ? (r_cnt + POS_W'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == OP_LOAD && w_load_ok) begin
            r_scratch[POS_W'(w_posn - POSN_W'(1))] <= w_mval;
        end
        r_m_rdata <= r_scratch[w_scr_raddr];
    end

    assign w_ctrl.init   = w_accept && (w_op == OP_BUILD);
    assign w_ctrl.step   = (r_state == S_BUILD);
    assign w_ctrl.mode   = w_mode;
    assign w_ctrl.degree = w_degree;
    assign w_ctrl.poly   = w_poly;
    assign w_ctrl.pos    = r_cnt;

    spg_build_unit u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_m     (r_m_rdata),
        .o_dir   (w_dir)
    );

    // The table read also runs one word ahead: word zero is fetched as the item
    // is taken, so the first evaluate cycle already sees it.
    assign w_tbl_raddr = (r_state == S_IDLE) ? {DIM_AW'(w_dim), POS_W'(0)}
                                             : {r_dim, POS_W'(r_cnt + POS_W'(1))};

    spg_dir_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_state == S_BUILD),
        .i_waddr ({r_dim, r_cnt}),
        .i_wdata (w_dir),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_eval_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_EVAL) |=> !o_s_axis_tready)
        else $error("input still ready after an evaluate transfer");

    a_point_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("output transfer raised outside the final evaluate state");

    a_walk_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && (n_state == S_BUILD || n_state == S_EVAL)) |=> r_cnt == '0)
        else $error("table walk did not start at word zero");

    a_build_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD && r_cnt == POS_W'(DIRS_PER_DIM - 1)) |=> r_state == S_IDLE)
        else $error("build did not end after the last direction number");

    a_done_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_axis_tready) |=> r_state == S_DONE)
        else $error("finished point left the accumulator while the output was stalled");

endmodule
